### src/md4_hash_engine_top_defines.svh
// assertion macros for the md4 hash engine
`ifndef MD4_HASH_ENGINE_TOP_DEFINES_SVH
`define MD4_HASH_ENGINE_TOP_DEFINES_SVH

// condition must hold in the same cycle
`define MD4_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the following cycle
`define MD4_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/md4_pkg.sv
// shared types, constants and microprogram for the md4 hash engine
`timescale 1ns / 1ps

package md4_pkg;

	// request codes
	localparam logic REQ_BYTE   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	// initial chaining words
	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;

	// round additive constants
	localparam logic [31:0] K_ROUND2 = 32'h5A827999;
	localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] PAD_LIMIT = 6'd55;
	localparam logic [5:0] LAST_POS  = 6'h3F;
	localparam logic [5:0] LAST_STEP = 6'd47;
	localparam logic [1:0] LAST_IDX  = 2'd3;
	localparam int         COUNT_W   = 61;

	typedef logic [2:0] upc_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] message_byte;
	} md4_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} md4_out_t;

	// micro-operations
	typedef enum logic [1:0] {
		UOP_WAIT,
		UOP_ROUND,
		UOP_ADD,
		UOP_EMIT
	} uop_t;

	// branch conditions
	typedef enum logic [1:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_FINISH,
		COND_SHORT_PAD
	} cond_t;

	// how the compression sees the block buffer
	typedef enum logic [1:0] {
		MODE_DATA,
		MODE_PAD,
		MODE_LEN
	} blk_mode_t;

	typedef struct packed {
		uop_t      op;
		cond_t     cond;
		blk_mode_t mode;
		upc_t      target;
	} ctl_t;

	// microprogram rom
	function automatic ctl_t prog_rom(upc_t pc);
		ctl_t c;
		case (pc)
			3'd0: c = '{UOP_WAIT,  COND_FINISH,    MODE_DATA, 3'd3};
			3'd1: c = '{UOP_ROUND, COND_NEXT,      MODE_DATA, 3'd0};
			3'd2: c = '{UOP_ADD,   COND_ALWAYS,    MODE_DATA, 3'd0};
			3'd3: c = '{UOP_ROUND, COND_NEXT,      MODE_PAD,  3'd0};
			3'd4: c = '{UOP_ADD,   COND_SHORT_PAD, MODE_PAD,  3'd7};
			3'd5: c = '{UOP_ROUND, COND_NEXT,      MODE_LEN,  3'd0};
			3'd6: c = '{UOP_ADD,   COND_NEXT,      MODE_LEN,  3'd0};
			3'd7: c = '{UOP_EMIT,  COND_ALWAYS,    MODE_DATA, 3'd0};
			default: c = '{UOP_WAIT, COND_NEXT, MODE_DATA, 3'd0};
		endcase
		return c;
	endfunction

	// message word order per step
	function automatic logic [3:0] word_order(logic [5:0] step);
		logic [3:0] j;
		logic [3:0] s;
		s = step[3:0];
		case (step[5:4])
			2'd0: j = s;
			2'd1: j = {s[1:0], s[3:2]};
			default: j = {s[0], s[1], s[2], s[3]};
		endcase
		return j;
	endfunction

	// rotate amount per round and step position
	function automatic logic [4:0] rot_amount(logic [1:0] rnd, logic [1:0] pos);
		logic [4:0] r;
		case ({rnd, pos})
			4'h0: r = 5'd3;
			4'h1: r = 5'd7;
			4'h2: r = 5'd11;
			4'h3: r = 5'd19;
			4'h4: r = 5'd3;
			4'h5: r = 5'd5;
			4'h6: r = 5'd9;
			4'h7: r = 5'd13;
			4'h8: r = 5'd3;
			4'h9: r = 5'd9;
			4'hA: r = 5'd11;
			4'hB: r = 5'd15;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

### src/md4_hash_engine_top.sv
// md4 hash engine: byte gathering, microcoded compression sequencer and digest output
// a message byte is taken while the sequencer waits; every 64th byte adds one compression and its add
// finish runs one compression (two when the pad byte lands past byte 55), then four digest transfers
// the shared round unit, one md4 step per cycle, sets the compression time
// reset loads the initial chaining words and clears the byte count and sequencer
// the block buffer has no reset; every word a compression reads is written first
`timescale 1ns / 1ps
`include "md4_hash_engine_top_defines.svh"

module md4_hash_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_ready,
	input  md4_pkg::md4_in_t  msg_item,
	output logic              dig_valid,
	input  logic              dig_ready,
	output md4_pkg::md4_out_t dig_item
);
	import md4_pkg::*;

	upc_t               pc_q;
	upc_t               pc_nxt;
	ctl_t               ctl;
	logic [5:0]         round_q;
	logic [1:0]         idx_q;
	logic [COUNT_W-1:0] count_q;
	logic [31:0]        chain_q [4];
	logic [31:0]        v_q [4];
	logic [31:0]        blk_q [16];
	logic [5:0]         pos;
	logic               msg_xfer;
	logic               dig_xfer;
	logic               hold;
	logic               take;
	logic               round_last;
	logic               digest_done;
	logic [3:0]         widx;
	logic [31:0]        mword;
	logic [31:0]        fval;
	logic [31:0]        kval;
	logic [31:0]        step_sum;
	logic [31:0]        step_rot;
	logic [4:0]         ramt;

	// present the buffer word with padding and length applied
	function automatic logic [31:0] form_word(blk_mode_t mode, logic [31:0] raw,
			logic [3:0] j, logic [5:0] p, logic [COUNT_W-1:0] cnt);
		logic [31:0] w;
		logic [5:0]  b;
		logic        with_len;
		w = raw;
		with_len = (mode == MODE_LEN) || ((mode == MODE_PAD) && (p <= PAD_LIMIT));
		if (mode != MODE_DATA) begin
			for (int k = 0; k < 4; k++) begin
				b = {j, 2'(k)};
				if ((mode == MODE_LEN) || (b > p)) begin
					w[8*k +: 8] = 8'h00;
				end else if (b == p) begin
					w[8*k +: 8] = PAD_BYTE;
				end
			end
		end
		if (with_len && (j == 4'd14)) begin
			w = {cnt[28:0], 3'b000};
		end else if (with_len && (j == 4'd15)) begin
			w = cnt[COUNT_W-1:29];
		end
		return w;
	endfunction

	// decode of the current control word
	assign ctl         = prog_rom(pc_q);
	assign pos         = count_q[5:0];
	assign msg_ready   = (ctl.op == UOP_WAIT);
	assign dig_valid   = (ctl.op == UOP_EMIT);
	assign msg_xfer    = msg_valid && msg_ready;
	assign dig_xfer    = dig_valid && dig_ready;
	assign round_last  = (round_q == LAST_STEP);
	assign digest_done = dig_xfer && (idx_q == LAST_IDX);

	// digest output straight from the chaining registers
	assign dig_item.digest_word = chain_q[idx_q];
	assign dig_item.word_index  = idx_q;
	assign dig_item.last_word   = (idx_q == LAST_IDX);

	// next step of the microprogram
	always_comb begin
		hold = 1'b0;
		case (ctl.op)
			UOP_WAIT: hold = !(msg_xfer &&
				((msg_item.req_type == REQ_FINISH) || (pos == LAST_POS)));
			UOP_ROUND: hold = !round_last;
			UOP_EMIT: hold = !digest_done;
			default: hold = 1'b0;
		endcase
		case (ctl.cond)
			COND_ALWAYS: take = 1'b1;
			COND_FINISH: take = (msg_item.req_type == REQ_FINISH);
			COND_SHORT_PAD: take = (pos <= PAD_LIMIT);
			default: take = 1'b0;
		endcase
		if (hold) begin
			pc_nxt = pc_q;
		end else if (take) begin
			pc_nxt = ctl.target;
		end else begin
			pc_nxt = pc_q + 3'd1;
		end
	end

	// round function of one md4 step
	always_comb begin
		widx  = word_order(round_q);
		mword = form_word(ctl.mode, blk_q[widx], widx, pos, count_q);
		case (round_q[5:4])
			2'd0: begin
				fval = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
				kval = '0;
			end
			2'd1: begin
				fval = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
				kval = K_ROUND2;
			end
			default: begin
				fval = v_q[1] ^ v_q[2] ^ v_q[3];
				kval = K_ROUND3;
			end
		endcase
		ramt     = rot_amount(round_q[5:4], round_q[1:0]);
		step_sum = v_q[0] + fval + mword + kval;
		step_rot = (step_sum << ramt) | (step_sum >> (6'd32 - {1'b0, ramt}));
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			round_q <= '0;
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			pc_q <= pc_nxt;
			if ((ctl.op == UOP_ROUND) && !round_last) begin
				round_q <= round_q + 6'd1;
			end else begin
				round_q <= '0;
			end
			if (dig_xfer) begin
				idx_q <= idx_q + 2'd1;
			end
			if (digest_done) begin
				count_q <= '0;
			end else if (msg_xfer && (msg_item.req_type == REQ_BYTE)) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	// chaining value: add after compression, reinitialise after the digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
		end else if (digest_done) begin
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
		end else if (ctl.op == UOP_ADD) begin
			for (int i = 0; i < 4; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	// working registers rotate one place per step, take the sum on the add and reload from the chaining words otherwise
	always_ff @(posedge clk) begin
		if (ctl.op == UOP_ROUND) begin
			v_q[0] <= v_q[3];
			v_q[1] <= step_rot;
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
		end else if (ctl.op == UOP_ADD) begin
			for (int i = 0; i < 4; i++) begin
				v_q[i] <= chain_q[i] + v_q[i];
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				v_q[i] <= chain_q[i];
			end
		end
	end

	// block buffer, one byte lane written per message byte
	always_ff @(posedge clk) begin
		if (msg_xfer && (msg_item.req_type == REQ_BYTE)) begin
			blk_q[pos[5:2]][8*pos[1:0] +: 8] <= msg_item.message_byte;
		end
	end

	// checks
	`MD4_ASSERT_SAME(a_one_side, msg_ready, !dig_valid, "input and digest side active together")
	`MD4_ASSERT_SAME(a_round_in_seq, round_q != 6'd0, ctl.op == UOP_ROUND,
		"round counter running outside a compression")
	`MD4_ASSERT_SAME(a_idx_in_emit, idx_q != 2'd0, ctl.op == UOP_EMIT,
		"digest index left over outside output phase")
	`MD4_ASSERT_NEXT(a_reinit, digest_done, (count_q == '0) && (chain_q[0] == INIT_A),
		"state not reinitialised after digest")

endmodule

### sim/md4_digest_checker.sv
// checker for the md4 hash engine: predicts digest words from accepted requests and compares them
`timescale 1ns / 1ps

module md4_digest_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	input  logic              msg_ready,
	input  md4_pkg::md4_in_t  msg_item,
	input  logic              dig_valid,
	input  logic              dig_ready,
	input  md4_pkg::md4_out_t dig_item,
	output int                mismatch_count,
	output int                words_outstanding
);
	import md4_pkg::*;

	// keep the log readable when everything goes wrong
	localparam int REPORT_CAP = 60;

	// message word taken by each of the 48 steps
	localparam logic [0:47][3:0] STEP_WORD = {
		4'd0, 4'd1, 4'd2,  4'd3,  4'd4, 4'd5,  4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd0, 4'd4, 4'd8,  4'd12, 4'd1, 4'd5,  4'd9, 4'd13,
		4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7,  4'd11, 4'd15,
		4'd0, 4'd8, 4'd4,  4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
		4'd1, 4'd9, 4'd5,  4'd13, 4'd3, 4'd11, 4'd7, 4'd15
	};

	// left rotation per round and step position
	localparam logic [0:11][4:0] STEP_SHIFT = {
		5'd3, 5'd7, 5'd11, 5'd19,
		5'd3, 5'd5, 5'd9,  5'd13,
		5'd3, 5'd9, 5'd11, 5'd15
	};

	logic [31:0]        chain_words [4];
	logic [7:0]         block_bytes [64];
	logic [COUNT_W-1:0] byte_total;
	md4_out_t           digest_queue [$];

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// back to the initial chaining words and an empty message
	task automatic restart_hash();
		chain_words[0] = INIT_A;
		chain_words[1] = INIT_B;
		chain_words[2] = INIT_C;
		chain_words[3] = INIT_D;
		byte_total = '0;
	endtask

	// one full block through the three rounds, added into the chaining words
	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] v [4];
		logic [31:0] b, c, d, f, k;
		int t, rnd, i;
		for (i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
		for (i = 0; i < 4; i++)
			v[i] = chain_words[i];
		for (i = 0; i < 48; i++) begin
			// target walks A, D, C, B
			t = (4 - (i % 4)) % 4;
			b = v[(t + 1) % 4];
			c = v[(t + 2) % 4];
			d = v[(t + 3) % 4];
			rnd = i / 16;
			if (rnd == 0) begin
				f = (b & c) | (~b & d);
				k = '0;
			end else if (rnd == 1) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_ROUND2;
			end else begin
				f = b ^ c ^ d;
				k = K_ROUND3;
			end
			v[t] = rotl32(v[t] + f + w[STEP_WORD[i]] + k, STEP_SHIFT[rnd * 4 + i % 4]);
		end
		for (i = 0; i < 4; i++)
			chain_words[i] = chain_words[i] + v[i];
	endtask

	// store a message byte, compress when the block fills
	task automatic absorb_byte(input logic [7:0] value);
		logic [5:0] pos;
		pos = byte_total[5:0];
		block_bytes[pos] = value;
		byte_total = byte_total + 1'b1;
		if (pos == LAST_POS)
			compress_block();
	endtask

	// pad, append the bit length, queue the four digest words and start over
	task automatic finish_digest();
		logic [63:0] bit_len;
		md4_out_t    dw;
		int          pos, i;
		bit_len = {byte_total, 3'b000};
		pos = byte_total[5:0];
		block_bytes[pos] = PAD_BYTE;
		pos++;
		// no room for the length: close this block first
		if (pos > 56) begin
			while (pos < 64) begin
				block_bytes[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			block_bytes[pos] = 8'h00;
			pos++;
		end
		for (i = 0; i < 8; i++)
			block_bytes[56 + i] = bit_len[8*i +: 8];
		compress_block();
		for (i = 0; i < 4; i++) begin
			dw.digest_word = chain_words[i];
			dw.word_index  = 2'(i);
			dw.last_word   = (i == LAST_IDX);
			digest_queue.push_back(dw);
		end
		restart_hash();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < REPORT_CAP)
			$display("%0t ns: %s is %0h, %0h expected", $time, what, got, want);
		mismatch_count++;
	endtask

	// output transfers are checked before the same edge's input transfer is predicted
	always @(posedge clk or negedge arst_n) begin
		md4_out_t want;
		if (!arst_n) begin
			restart_hash();
			digest_queue.delete();
			mismatch_count = 0;
		end else begin
			if (dig_valid && dig_ready) begin
				if (digest_queue.size() == 0) begin
					report_mismatch("unexpected digest word", dig_item.digest_word, '0);
				end else begin
					want = digest_queue.pop_front();
					if (dig_item.digest_word !== want.digest_word)
						report_mismatch("digest_word", dig_item.digest_word, want.digest_word);
					if (dig_item.word_index !== want.word_index)
						report_mismatch("word_index", dig_item.word_index, want.word_index);
					if (dig_item.last_word !== want.last_word)
						report_mismatch("last_word", dig_item.last_word, want.last_word);
				end
			end
			if (msg_valid && msg_ready) begin
				if (msg_item.req_type == REQ_FINISH)
					finish_digest();
				else
					absorb_byte(msg_item.message_byte);
			end
		end
		words_outstanding = digest_queue.size();
	end

endmodule

### sim/tb_top.sv
// testbench top for the md4 hash engine: clock, reset, request stimulus, digest sink and verdict
`timescale 1ns / 1ps

module tb_top;
	import md4_pkg::*;

	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 150;
	localparam int ITEM_TARGET    = 450;
	localparam int FINISH_TARGET  = 12;

	logic     clk;
	logic     arst_n;
	logic     msg_valid;
	logic     msg_ready;
	md4_in_t  msg_item;
	logic     dig_valid;
	logic     dig_ready;
	md4_out_t dig_item;

	int   mismatch_count;
	int   words_outstanding;
	int   items_sent;
	int   finishes_sent;
	int   idle_cycles;
	logic hold_req;
	logic sender_steady;

	md4_hash_engine_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg_item  (msg_item),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig_item  (dig_item)
	);

	md4_digest_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.msg_valid         (msg_valid),
		.msg_ready         (msg_ready),
		.msg_item          (msg_item),
		.dig_valid         (dig_valid),
		.dig_ready         (dig_ready),
		.dig_item          (dig_item),
		.mismatch_count    (mismatch_count),
		.words_outstanding (words_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// message lengths: mostly short, often on the padding boundaries, a few spanning two or three blocks
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(0, 12);
		if (r < 78) begin
			case ($urandom_range(0, 7))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				5: return 65;
				6: return 119;
				default: return 120;
			endcase
		end
		if (r < 92)
			return $urandom_range(13, 54);
		return $urandom_range(100, 130);
	endfunction

	// offer one request and hold it until the transfer
	task automatic put_req(input logic req, input logic [7:0] value);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_valid <= 1'b1;
		msg_item  <= '{req_type: req, message_byte: value};
		@(posedge clk);
		while (!msg_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (req == REQ_FINISH)
			finishes_sent++;
	endtask

	task automatic send_message(input int len);
		repeat (len)
			put_req(REQ_BYTE, 8'($urandom_range(0, 255)));
		put_req(REQ_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// sender stays quiet until every digest word has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (words_outstanding != 0);
	endtask

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		msg_valid     = 1'b0;
		msg_item      = '0;
		hold_req      = 1'b0;
		sender_steady = 1'b0;
		items_sent    = 0;
		finishes_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, extreme single bytes, the three-byte text, stray byte on finish
		put_req(REQ_FINISH, 8'h00);
		put_req(REQ_BYTE, 8'h00);
		put_req(REQ_FINISH, 8'h00);
		put_req(REQ_BYTE, 8'hFF);
		put_req(REQ_FINISH, 8'h00);
		put_req(REQ_BYTE, 8'h61);
		put_req(REQ_BYTE, 8'h62);
		put_req(REQ_BYTE, 8'h63);
		put_req(REQ_FINISH, 8'h00);
		put_req(REQ_FINISH, 8'hFF);
		put_req(REQ_BYTE, 8'h55);
		put_req(REQ_BYTE, 8'hAA);
		put_req(REQ_FINISH, 8'h5A);

		msg_valid <= 1'b0;
		wait_drained();

		// sink holds off while short messages keep coming, so the engine backs up
		hold_req <= 1'b1;
		repeat (6)
			send_message($urandom_range(0, 3));

		// random messages, some sent back to back with no gaps
		while (items_sent < ITEM_TARGET || finishes_sent < FINISH_TARGET) begin
			sender_steady = ($urandom_range(0, 3) == 0);
			send_message(pick_length());
		end
		msg_valid <= 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && words_outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// digest sink: random stalls and runs, plus one long hold-off on request
	initial begin
		int   stall_left;
		int   run_left;
		logic hold_done;
		stall_left = 0;
		run_left   = 0;
		hold_done  = 1'b0;
		dig_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done  = 1'b1;
				stall_left = LONG_HOLD;
				run_left   = 0;
			end
			if (stall_left > 0) begin
				dig_ready <= 1'b0;
				stall_left--;
			end else if (run_left > 0) begin
				dig_ready <= 1'b1;
				run_left--;
			end else begin
				dig_ready  <= 1'b1;
				stall_left = pick_gap();
				run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
					: $urandom_range(1, 12);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (msg_valid && msg_ready) || (dig_valid && dig_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
